[rtl/gcmmb_pkg.sv]
// Shared constants, register indexes, FSM state type and divider status type
// for the grid cell min/max binning block. No dependencies.
`default_nettype none

package gcmmb_pkg;

    // Default sizes of the grid store and of the point coordinates
    localparam int MAX_COLS_DEF   = 64;
    localparam int MAX_ROWS_DEF   = 64;
    localparam int COORD_BITS_DEF = 32;

    // Fixed field widths
    localparam int OFS_BITS   = 26;
    localparam int CS_W       = 21;
    localparam int GW_W       = 7;
    localparam int RC_W       = 6;
    localparam int CIDX_W     = 12;
    localparam int SUM_W      = 2 * GW_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [CS_W-1:0] CS_RESET = CS_W'(1000);
    localparam logic [GW_W-1:0] GW_RESET = GW_W'(64);
    localparam logic [GW_W-1:0] GH_RESET = GW_W'(64);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_X_MIN       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(4);

    // Request function codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_INDEX,
        ST_MEMRD,
        ST_MODIFY,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[rtl/gcmmb_req_if.sv]
// Request channel: valid/ready with one insert or read word.
// Depends on gcmmb_pkg for the cell column/row width.
`default_nettype none

interface gcmmb_req_if
    import gcmmb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic        [RC_W-1:0]       cell_col;
    logic        [RC_W-1:0]       cell_row;

    modport source (
        output valid, func, point_x, point_y, point_z, cell_col, cell_row,
        input  ready
    );

    modport sink (
        input  valid, func, point_x, point_y, point_z, cell_col, cell_row,
        output ready
    );
endinterface

`default_nettype wire

[rtl/gcmmb_rsp_if.sv]
// Response channel: valid/ready with one cell record word.
// Depends on gcmmb_pkg for the offset and cell index widths.
`default_nettype none

interface gcmmb_rsp_if
    import gcmmb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic        [CIDX_W-1:0]     cell_index;
    logic                         occupied;
    logic        [OFS_BITS-1:0]   low_x;
    logic        [OFS_BITS-1:0]   low_y;
    logic signed [COORD_BITS-1:0] low_z;
    logic        [OFS_BITS-1:0]   high_x;
    logic        [OFS_BITS-1:0]   high_y;
    logic signed [COORD_BITS-1:0] high_z;

    modport source (
        output valid, status, cell_index, occupied,
               low_x, low_y, low_z, high_x, high_y, high_z,
        input  ready
    );

    modport sink (
        input  valid, status, cell_index, occupied,
               low_x, low_y, low_z, high_x, high_y, high_z,
        output ready
    );
endinterface

`default_nettype wire

[rtl/gcmmb_cfg_if.sv]
// Configuration write channel: valid/ready with register index and data.
// Depends on gcmmb_pkg for the index and data widths.
`default_nettype none

interface gcmmb_cfg_if
    import gcmmb_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

[rtl/gcmmb_div.sv]
// Dual-lane restoring divider: two dividends over one shared divisor,
// one quotient bit per lane per cycle. Depends on gcmmb_pkg.
`default_nettype none

module gcmmb_div
    import gcmmb_pkg::*;
#(
    parameter int QW = OFS_BITS,
    parameter int DW = CS_W
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [QW-1:0] dividend_a,
    input  wire logic [QW-1:0] dividend_b,
    input  wire logic [DW-1:0] divisor,
    output div_stat_t          stat,
    output logic      [QW-1:0] quot_a,
    output logic      [QW-1:0] quot_b
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [QW-1:0]    qa_reg;
    logic [QW-1:0]    qb_reg;
    logic [DW-1:0]    ra_reg;
    logic [DW-1:0]    rb_reg;

    logic [DW:0]      trial_a;
    logic [DW:0]      trial_b;
    logic [DW:0]      dvs;
    logic             geq_a;
    logic             geq_b;
    logic [DW-1:0]    ra_next;
    logic [DW-1:0]    rb_next;

    always_comb
    begin
        dvs     = {1'b0, divisor};
        trial_a = {ra_reg, qa_reg[QW-1]};
        trial_b = {rb_reg, qb_reg[QW-1]};
        geq_a   = trial_a >= dvs;
        geq_b   = trial_b >= dvs;
        // remainder stays below the divisor, so the difference fits DW bits
        ra_next = geq_a ? DW'(trial_a - dvs) : trial_a[DW-1:0];
        rb_next = geq_b ? DW'(trial_b - dvs) : trial_b[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(QW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift quotient bits in from the right as dividend bits leave on the left
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qa_reg <= dividend_a;
            qb_reg <= dividend_b;
            ra_reg <= '0;
            rb_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            qa_reg <= {qa_reg[QW-2:0], geq_a};
            qb_reg <= {qb_reg[QW-2:0], geq_b};
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
    end

    assign stat.busy = cnt_reg != '0;
    assign stat.done = done_reg;
    assign quot_a    = qa_reg;
    assign quot_b    = qb_reg;

endmodule

`default_nettype wire

[rtl/grid_cell_min_max_binning_core.sv]
// Grid cell min/max binning core: cell store, request sequencer, config
// registers. Depends on gcmmb_pkg, gcmmb_req_if/rsp_if/cfg_if and gcmmb_div.
//
// Usage:
//   req  - one word per request: func=insert bins point (x, y, z) into the
//          grid and answers with the updated cell; func=read answers with
//          the record of cell (cell_col, cell_row).
//   rsp  - one word per request, in request order: status, cell index,
//          occupied flag, lowest and highest point of the cell.
//   cfg  - register writes, always ready; write only while no request is
//          in flight.
// Sequence: one request at a time. An insert goes through PREP, DIV (the
//   divider makes 26 quotient bits, column and row together), INDEX,
//   MEMRD, MODIFY and RESULT; a read skips DIV. The next request is
//   accepted once the sequencer is back in IDLE.
// Reset: a clearing pass walks all MAX_COLS * MAX_ROWS store entries
//   (4096 by default), one entry per cycle; req.ready stays low until it
//   ends.
// Stall: the response sits in an output register; the next request is
//   accepted while it waits, and its own result holds until rsp.ready.
`default_nettype none

module grid_cell_min_max_binning_core
    import gcmmb_pkg::*;
#(
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic     clk,
    input wire logic     rst_n,
    gcmmb_req_if.sink    req,
    gcmmb_rsp_if.source  rsp,
    gcmmb_cfg_if.sink    cfg
);

    localparam int CELLS  = MAX_COLS * MAX_ROWS;
    localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int XW     = ((COORD_BITS > CFG_DATA_W) ? COORD_BITS : CFG_DATA_W) + 1;
    localparam int REC_W  = 2 * OFS_BITS;
    localparam int HALF_W = REC_W + COORD_BITS;
    localparam int WORD_W = 1 + 2 * HALF_W;

    // store word: {occupied, low {z, y, x}, high {z, y, x}}
    logic [WORD_W-1:0] mem [CELLS];

    state_t state_reg;
    state_t state_next;

    logic signed [CFG_DATA_W-1:0] x_min_reg;
    logic signed [CFG_DATA_W-1:0] y_min_reg;
    logic        [CS_W-1:0]       cell_size_reg;
    logic        [GW_W-1:0]       grid_w_reg;
    logic        [GW_W-1:0]       grid_h_reg;

    logic                         func_reg;
    logic signed [XW-1:0]         dx_reg;
    logic signed [XW-1:0]         dy_reg;
    logic signed [COORD_BITS-1:0] z_reg;
    logic        [OFS_BITS-1:0]   col_reg;
    logic        [OFS_BITS-1:0]   row_reg;
    logic        [IDX_W-1:0]      idx_reg;
    logic        [CIDX_W-1:0]     cidx_reg;
    logic        [IDX_W-1:0]      clr_cnt_reg;
    logic        [WORD_W-1:0]     rd_word_reg;

    logic                         res_status_reg;
    logic        [CIDX_W-1:0]     res_cidx_reg;
    logic        [WORD_W-1:0]     res_word_reg;
    logic                         res_status_next;
    logic        [CIDX_W-1:0]     res_cidx_next;
    logic        [WORD_W-1:0]     res_word_next;

    logic                         out_valid_reg;
    logic                         out_status_reg;
    logic        [CIDX_W-1:0]     out_cidx_reg;
    logic        [WORD_W-1:0]     out_word_reg;

    logic                         accept;
    logic                         div_start;
    logic                         quot_ld;
    logic                         idx_ld;
    logic                         res_ld;
    logic                         out_ld;
    logic                         mem_we;
    logic        [IDX_W-1:0]      mem_waddr;
    logic        [WORD_W-1:0]     mem_wdata;

    logic        [GW_W-1:0]       eff_w;
    logic        [GW_W-1:0]       eff_h;
    logic        [CS_W-1:0]       cs_eff;
    logic                         ofs_bad;
    logic                         cell_bad;
    logic        [SUM_W-1:0]      lin_idx;

    logic                         cur_occ;
    logic        [HALF_W-1:0]     cur_lo;
    logic        [HALF_W-1:0]     cur_hi;
    logic signed [COORD_BITS-1:0] cur_lo_z;
    logic signed [COORD_BITS-1:0] cur_hi_z;
    logic        [HALF_W-1:0]     pt_half;
    logic        [HALF_W-1:0]     new_lo;
    logic        [HALF_W-1:0]     new_hi;
    logic        [WORD_W-1:0]     new_word;

    div_stat_t                    div_stat;
    logic        [OFS_BITS-1:0]   quot_x;
    logic        [OFS_BITS-1:0]   quot_y;

    gcmmb_div #(
        .QW (OFS_BITS),
        .DW (CS_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend_a (dx_reg[OFS_BITS-1:0]),
        .dividend_b (dy_reg[OFS_BITS-1:0]),
        .divisor    (cs_eff),
        .stat       (div_stat),
        .quot_a     (quot_x),
        .quot_b     (quot_y)
    );

    // ---------------- grid geometry ----------------
    always_comb
    begin
        if (int'(grid_w_reg) > MAX_COLS)
        begin
            eff_w = GW_W'(MAX_COLS);
        end
        else
        begin
            eff_w = grid_w_reg;
        end
        if (int'(grid_h_reg) > MAX_ROWS)
        begin
            eff_h = GW_W'(MAX_ROWS);
        end
        else
        begin
            eff_h = grid_h_reg;
        end
        cs_eff   = (cell_size_reg == '0) ? CS_W'(1) : cell_size_reg;
        // negative offsets land in the upper bits too
        ofs_bad  = (|dx_reg[XW-1:OFS_BITS]) || (|dy_reg[XW-1:OFS_BITS]);
        cell_bad = (col_reg >= OFS_BITS'(eff_w)) || (row_reg >= OFS_BITS'(eff_h));
        // row and column are below the 7-bit grid size once the check passes
        lin_idx  = SUM_W'(row_reg[GW_W-1:0]) * SUM_W'(eff_w)
                 + SUM_W'(col_reg[GW_W-1:0]);
    end

    // ---------------- cell update ----------------
    always_comb
    begin
        cur_occ  = rd_word_reg[WORD_W-1];
        cur_lo   = rd_word_reg[HALF_W +: HALF_W];
        cur_hi   = rd_word_reg[0 +: HALF_W];
        cur_lo_z = cur_lo[REC_W +: COORD_BITS];
        cur_hi_z = cur_hi[REC_W +: COORD_BITS];
        pt_half  = {z_reg, dy_reg[OFS_BITS-1:0], dx_reg[OFS_BITS-1:0]};
        // replace only on strict improvement, the earlier point wins a tie
        new_lo   = (!cur_occ || (z_reg < cur_lo_z)) ? pt_half : cur_lo;
        new_hi   = (!cur_occ || (z_reg > cur_hi_z)) ? pt_half : cur_hi;
        new_word = {1'b1, new_lo, new_hi};
    end

    // ---------------- sequencer ----------------
    assign accept    = req.valid && req.ready;
    assign req.ready = state_reg == ST_IDLE;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        div_start       = 1'b0;
        quot_ld         = 1'b0;
        idx_ld          = 1'b0;
        res_ld          = 1'b0;
        out_ld          = 1'b0;
        res_status_next = STATUS_OK;
        res_cidx_next   = cidx_reg;
        res_word_next   = '0;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = new_word;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == IDX_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (func_reg == FUNC_READ)
                begin
                    state_next = ST_INDEX;
                end
                else if (ofs_bad)
                begin
                    res_ld          = 1'b1;
                    res_status_next = STATUS_OUTSIDE;
                    res_cidx_next   = '0;
                    state_next      = ST_RESULT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    quot_ld    = 1'b1;
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                if (cell_bad)
                begin
                    res_ld          = 1'b1;
                    res_status_next = STATUS_OUTSIDE;
                    res_cidx_next   = '0;
                    state_next      = ST_RESULT;
                end
                else
                begin
                    idx_ld     = 1'b1;
                    state_next = ST_MEMRD;
                end
            end
            ST_MEMRD:
            begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                res_ld = 1'b1;
                if (func_reg == FUNC_INSERT)
                begin
                    mem_we        = 1'b1;
                    res_word_next = new_word;
                end
                else
                begin
                    res_word_next = cur_occ ? rd_word_reg : '0;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_ld     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            x_min_reg     <= '0;
            y_min_reg     <= '0;
            cell_size_reg <= CS_RESET;
            grid_w_reg    <= GW_RESET;
            grid_h_reg    <= GH_RESET;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_X_MIN:       x_min_reg     <= cfg.data;
                    REG_Y_MIN:       y_min_reg     <= cfg.data;
                    REG_CELL_SIZE:   cell_size_reg <= cfg.data[CS_W-1:0];
                    REG_GRID_WIDTH:  grid_w_reg    <= cfg.data[GW_W-1:0];
                    REG_GRID_HEIGHT: grid_h_reg    <= cfg.data[GW_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            dx_reg   <= XW'(req.point_x) - XW'(x_min_reg);
            dy_reg   <= XW'(req.point_y) - XW'(y_min_reg);
            z_reg    <= req.point_z;
            col_reg  <= OFS_BITS'(req.cell_col);
            row_reg  <= OFS_BITS'(req.cell_row);
        end
        else if (quot_ld)
        begin
            col_reg <= quot_x;
            row_reg <= quot_y;
        end
        if (idx_ld)
        begin
            idx_reg  <= IDX_W'(lin_idx);
            cidx_reg <= lin_idx[CIDX_W-1:0];
        end
        if (res_ld)
        begin
            res_status_reg <= res_status_next;
            res_cidx_reg   <= res_cidx_next;
            res_word_reg   <= res_word_next;
        end
        if (out_ld)
        begin
            out_status_reg <= res_status_reg;
            out_cidx_reg   <= res_cidx_reg;
            out_word_reg   <= res_word_reg;
        end
    end

    // ---------------- cell store ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_word_reg <= mem[idx_reg];
    end

    // ---------------- response ----------------
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.cell_index = out_cidx_reg;
    assign rsp.occupied   = out_word_reg[WORD_W-1];
    assign rsp.low_x      = out_word_reg[HALF_W +: OFS_BITS];
    assign rsp.low_y      = out_word_reg[HALF_W + OFS_BITS +: OFS_BITS];
    assign rsp.low_z      = out_word_reg[HALF_W + REC_W +: COORD_BITS];
    assign rsp.high_x     = out_word_reg[0 +: OFS_BITS];
    assign rsp.high_y     = out_word_reg[OFS_BITS +: OFS_BITS];
    assign rsp.high_z     = out_word_reg[REC_W +: COORD_BITS];

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request accepted while another is in flight");

    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy || div_stat.done) |-> state_reg == ST_DIV)
        else $error("divider active outside the divide state");

    a_outside_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STATUS_OUTSIDE) |->
            (rsp.cell_index == '0 && !rsp.occupied))
        else $error("outside-grid response carries cell data");

    a_empty_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.occupied) |-> (rsp.low_z == '0 && rsp.high_z == '0))
        else $error("empty cell response carries a record");
`endif

endmodule

`default_nettype wire

[dv/tb_grid_cell_min_max_binning_core.sv]
`timescale 1ns / 100ps
// Testbench for grid_cell_min_max_binning_core: random and directed insert/read
// words, own cell-store predictor, in-order response check. Needs gcmmb_pkg,
// the req/rsp/cfg interfaces and the core RTL.

module tb_grid_cell_min_max_binning_core;
    import gcmmb_pkg::*;

    localparam int  CB           = COORD_BITS_DEF;
    localparam int  CELLS        = MAX_COLS_DEF * MAX_ROWS_DEF;
    localparam longint OFS_MAX   = (longint'(1) << OFS_BITS) - 1;
    localparam int  LIMIT_CYCLES = 400000;
    localparam int  HOLD_CYCLES  = 600;
    localparam int  MAX_PRINTS   = 60;

    typedef struct packed {
        logic                 func;
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        logic [RC_W-1:0]      col;
        logic [RC_W-1:0]      row;
    } bin_req_t;

    typedef struct packed {
        logic                  status;
        logic [CIDX_W-1:0]     index;
        logic                  occupied;
        logic [OFS_BITS-1:0]   low_x;
        logic [OFS_BITS-1:0]   low_y;
        logic signed [CB-1:0]  low_z;
        logic [OFS_BITS-1:0]   high_x;
        logic [OFS_BITS-1:0]   high_y;
        logic signed [CB-1:0]  high_z;
    } cell_word_t;

    logic clk;
    logic rst_n;

    gcmmb_req_if req_if ();
    gcmmb_rsp_if rsp_if ();
    gcmmb_cfg_if cfg_if ();

    grid_cell_min_max_binning_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // Shadow of the configuration registers
    bit signed [CB-1:0] sh_x_min;
    bit signed [CB-1:0] sh_y_min;
    bit [CS_W-1:0]      sh_cell_size;
    bit [GW_W-1:0]      sh_grid_w;
    bit [GW_W-1:0]      sh_grid_h;

    // Predicted cell store
    bit                  occ_map  [CELLS];
    bit [OFS_BITS-1:0]   lo_x_mem [CELLS];
    bit [OFS_BITS-1:0]   lo_y_mem [CELLS];
    bit signed [CB-1:0]  lo_z_mem [CELLS];
    bit [OFS_BITS-1:0]   hi_x_mem [CELLS];
    bit [OFS_BITS-1:0]   hi_y_mem [CELLS];
    bit signed [CB-1:0]  hi_z_mem [CELLS];

    bin_req_t   pending_reqs [$];
    cell_word_t exp_cells    [$];
    bin_req_t   cur_req;
    cell_word_t want_cell;

    int  err_count  = 0;
    int  cycle_cnt  = 0;
    int  src_gap    = 0;
    int  snk_gap    = 0;
    bit  quiet_tail = 0;
    bit  hold_go    = 0;
    logic long_hold;

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    function automatic longint cols_in_use();
        return (sh_grid_w > MAX_COLS_DEF) ? MAX_COLS_DEF : sh_grid_w;
    endfunction

    function automatic longint rows_in_use();
        return (sh_grid_h > MAX_ROWS_DEF) ? MAX_ROWS_DEF : sh_grid_h;
    endfunction

    function automatic longint cell_edge();
        return (sh_cell_size == 0) ? 1 : sh_cell_size;
    endfunction

    function automatic void set_shadow_reg(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_X_MIN:       sh_x_min     = val;
            REG_Y_MIN:       sh_y_min     = val;
            REG_CELL_SIZE:   sh_cell_size = val[CS_W-1:0];
            REG_GRID_WIDTH:  sh_grid_w    = val[GW_W-1:0];
            REG_GRID_HEIGHT: sh_grid_h    = val[GW_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic cell_word_t cell_record(input int idx);
        cell_word_t c = '0;
        c.status   = STATUS_OK;
        c.index    = CIDX_W'(idx);
        c.occupied = occ_map[idx];
        if (occ_map[idx]) begin
            c.low_x  = lo_x_mem[idx];
            c.low_y  = lo_y_mem[idx];
            c.low_z  = lo_z_mem[idx];
            c.high_x = hi_x_mem[idx];
            c.high_y = hi_y_mem[idx];
            c.high_z = hi_z_mem[idx];
        end
        return c;
    endfunction

    // Bin one insert word into the predicted store, or look up a read word, and return the cell it answers with
    function automatic cell_word_t bin_and_record(input bin_req_t r);
        cell_word_t c = '0;
        longint w, h, cs, dx, dy, col, row;
        int idx;
        w  = cols_in_use();
        h  = rows_in_use();
        cs = cell_edge();
        if (r.func == FUNC_READ) begin
            if (r.col >= w || r.row >= h)
                c.status = STATUS_OUTSIDE;
            else
                c = cell_record(int'(r.row * w + r.col));
            return c;
        end
        dx = longint'(r.x) - longint'(sh_x_min);
        dy = longint'(r.y) - longint'(sh_y_min);
        if (dx < 0 || dy < 0 || dx > OFS_MAX || dy > OFS_MAX) begin
            c.status = STATUS_OUTSIDE;
            return c;
        end
        col = dx / cs;
        row = dy / cs;
        if (col >= w || row >= h) begin
            c.status = STATUS_OUTSIDE;
            return c;
        end
        idx = int'(row * w + col);
        if (!occ_map[idx]) begin
            occ_map[idx]  = 1'b1;
            lo_x_mem[idx] = dx[OFS_BITS-1:0];
            lo_y_mem[idx] = dy[OFS_BITS-1:0];
            lo_z_mem[idx] = r.z;
            hi_x_mem[idx] = dx[OFS_BITS-1:0];
            hi_y_mem[idx] = dy[OFS_BITS-1:0];
            hi_z_mem[idx] = r.z;
        end else begin
            // strict compares: on a tie the earlier point stays
            if (r.z < lo_z_mem[idx]) begin
                lo_x_mem[idx] = dx[OFS_BITS-1:0];
                lo_y_mem[idx] = dy[OFS_BITS-1:0];
                lo_z_mem[idx] = r.z;
            end
            if (r.z > hi_z_mem[idx]) begin
                hi_x_mem[idx] = dx[OFS_BITS-1:0];
                hi_y_mem[idx] = dy[OFS_BITS-1:0];
                hi_z_mem[idx] = r.z;
            end
        end
        return cell_record(idx);
    endfunction

    // Offset from the origin along one axis, mostly inside the grid
    function automatic longint aim_offset(input longint cs, input longint n);
        int unsigned k;
        longint c;
        k = $urandom_range(0, 19);
        if (k == 0)
            return -longint'($urandom_range(1, 1000));
        if (k == 1)
            return (longint'(1) << OFS_BITS) + $urandom_range(0, 3);
        if (k == 2)
            return OFS_MAX - $urandom_range(0, 3);
        // hot cells near the origin give repeated hits and ties
        c = (k < 12) ? $urandom_range(0, (n > 3) ? 3 : n) : $urandom_range(0, n);
        return c * cs + longint'($urandom_range(0, cs - 1));
    endfunction

    function automatic bin_req_t gen_bin_req();
        bin_req_t r;
        longint w, h, cs;
        int unsigned pick;
        w  = cols_in_use();
        h  = rows_in_use();
        cs = cell_edge();
        r.func = FUNC_INSERT;
        r.x    = $urandom;
        r.y    = $urandom;
        r.z    = $urandom;
        r.col  = RC_W'($urandom);
        r.row  = RC_W'($urandom);
        pick   = $urandom_range(0, 99);
        if (pick < 25) begin
            r.func = FUNC_READ;
            if (pick < 18) begin
                r.col = RC_W'($urandom_range(0, (w > 3) ? 3 : w));
                r.row = RC_W'($urandom_range(0, (h > 3) ? 3 : h));
            end
        end else if (pick < 90) begin
            r.x = CB'(longint'(sh_x_min) + aim_offset(cs, w));
            r.y = CB'(longint'(sh_y_min) + aim_offset(cs, h));
            case ($urandom_range(0, 5))
                0:       r.z = {1'b1, {(CB-1){1'b0}}};
                1:       r.z = {1'b0, {(CB-1){1'b1}}};
                2, 3:    r.z = int'($urandom_range(0, 6)) - 3;
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic push_req(input logic f, input logic [CB-1:0] x, input logic [CB-1:0] y,
                            input logic [CB-1:0] z, input logic [RC_W-1:0] col,
                            input logic [RC_W-1:0] row);
        bin_req_t r;
        r.func = f;
        r.x    = x;
        r.y    = y;
        r.z    = z;
        r.col  = col;
        r.row  = row;
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        set_shadow_reg(idx, val);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_grid(input logic [31:0] xm, input logic [31:0] ym, input logic [31:0] cs,
                            input logic [31:0] gw, input logic [31:0] gh);
        write_reg(REG_X_MIN, xm);
        write_reg(REG_Y_MIN, ym);
        write_reg(REG_CELL_SIZE, cs);
        write_reg(REG_GRID_WIDTH, gw);
        write_reg(REG_GRID_HEIGHT, gh);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || req_if.valid || exp_cells.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_random(input int n);
        @(negedge clk);
        repeat (n) pending_reqs = {pending_reqs, gen_bin_req()};
        wait_drained();
    endtask

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Request driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_if.valid && req_if.ready)
                exp_cells = {exp_cells, bin_and_record(cur_req)};
            if (!req_if.valid || req_if.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    req_if.valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 16);
                    req_if.valid <= 1'b0;
                end else begin
                    cur_req = pending_reqs.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.func     <= cur_req.func;
                    req_if.point_x  <= cur_req.x;
                    req_if.point_y  <= cur_req.y;
                    req_if.point_z  <= cur_req.z;
                    req_if.cell_col <= cur_req.col;
                    req_if.cell_row <= cur_req.row;
                end
            end
        end
    end

    // Response monitor and ready pattern
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (exp_cells.size() == 0) begin
                    report_mismatch("response word with no request outstanding");
                end else begin
                    want_cell = exp_cells.pop_front();
                    check_field("status",     rsp_if.status,     want_cell.status);
                    check_field("cell_index", rsp_if.cell_index, want_cell.index);
                    check_field("occupied",   rsp_if.occupied,   want_cell.occupied);
                    check_field("low_x",      rsp_if.low_x,      want_cell.low_x);
                    check_field("low_y",      rsp_if.low_y,      want_cell.low_y);
                    check_field("low_z",      rsp_if.low_z,      want_cell.low_z);
                    check_field("high_x",     rsp_if.high_x,     want_cell.high_x);
                    check_field("high_y",     rsp_if.high_y,     want_cell.high_y);
                    check_field("high_z",     rsp_if.high_z,     want_cell.high_z);
                end
            end
            if (long_hold) begin
                rsp_if.ready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                rsp_if.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                snk_gap = $urandom_range(0, 16);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Hold off the response side long enough for the block to back up
    initial begin
        long_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial begin
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.func     = FUNC_INSERT;
        req_if.point_x  = '0;
        req_if.point_y  = '0;
        req_if.point_z  = '0;
        req_if.cell_col = '0;
        req_if.cell_row = '0;
        rsp_if.ready    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        sh_x_min        = '0;
        sh_y_min        = '0;
        sh_cell_size    = CS_RESET;
        sh_grid_w       = GW_RESET;
        sh_grid_h       = GH_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words on the reset grid: origin 0, cell 1000, 64 x 64
        push_req(FUNC_READ,   0, 0, 0, 0, 0);                     // empty cell
        push_req(FUNC_INSERT, 0, 0, 0, 0, 0);                     // first point
        push_req(FUNC_INSERT, 999, 999, 0, 0, 0);                 // tie on both
        push_req(FUNC_INSERT, 500, 10, 100, 0, 0);
        push_req(FUNC_INSERT, 10, 500, -100, 0, 0);
        push_req(FUNC_INSERT, 20, 20, 100, 0, 0);                 // tie on high
        push_req(FUNC_INSERT, 1, 2, 32'h8000_0000, 0, 0);
        push_req(FUNC_INSERT, 3, 4, 32'h7fff_ffff, 0, 0);
        push_req(FUNC_READ,   0, 0, 0, 0, 0);
        push_req(FUNC_INSERT, 63999, 63999, 7, 0, 0);             // last cell
        push_req(FUNC_READ,   0, 0, 0, 63, 63);
        push_req(FUNC_READ,   0, 0, 0, 62, 63);
        push_req(FUNC_INSERT, 64000, 5, 0, 0, 0);                 // column past grid
        push_req(FUNC_INSERT, 5, 64000, 0, 0, 0);                 // row past grid
        push_req(FUNC_INSERT, -1, 5, 0, 0, 0);                    // left of origin
        push_req(FUNC_INSERT, 5, -1, 0, 0, 0);                    // below origin
        push_req(FUNC_INSERT, 32'h8000_0000, 32'h7fff_ffff, 1, 0, 0);
        push_req(FUNC_INSERT, 32'h0400_0000, 0, 0, 0, 0);
        push_req(FUNC_INSERT, 1000, 0, -5, 0, 0);
        push_req(FUNC_READ,   32'hffff_ffff, 32'h1234_5678, 32'hdead_beef, 1, 0);
        push_req(FUNC_INSERT, 2000, 3000, 9, 63, 63);
        push_req(FUNC_READ,   0, 0, 0, 63, 0);
        wait_drained();
        run_random(110);

        // Lowest origin, unit cells; back up the block during this phase
        set_grid(32'h8000_0000, 32'h8000_3039, 1, 64, 64);
        hold_go = 1'b1;
        run_random(100);

        // Highest origin on a 1 x 1 grid
        set_grid(32'h7fff_ffff, 32'h7fff_ffff, 1, 1, 1);
        @(negedge clk);
        push_req(FUNC_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 42, 0, 0);
        push_req(FUNC_INSERT, 32'h7fff_fffe, 32'h7fff_ffff, 42, 0, 0);
        push_req(FUNC_READ,   0, 0, 0, 0, 0);
        push_req(FUNC_READ,   0, 0, 0, 1, 0);
        run_random(40);

        // Zero cell size, grid sizes above the store limit
        set_grid($urandom, $urandom, 32'hffe0_0000, 127, 32'hffff_ff64);
        run_random(100);

        // No columns at all
        set_grid($urandom, $urandom, $urandom_range(1, 3000), 0, 64);
        run_random(30);

        // Cell size 0x100000: the 26-bit offset limit decides the edge
        set_grid(32'hfe00_0000, 0, 32'h0010_0000, 64, 64);
        @(negedge clk);
        push_req(FUNC_INSERT, 32'h01ff_ffff, 32'h03ff_ffff, -7, 0, 0);
        push_req(FUNC_INSERT, 32'h0200_0000, 0, 3, 0, 0);
        push_req(FUNC_INSERT, 0, 32'h0400_0000, 3, 0, 0);
        push_req(FUNC_READ,   0, 0, 0, 63, 63);
        run_random(100);

        // Widest cell field value and a reshaped grid over the old entries
        set_grid($urandom, $urandom, 32'hffff_ffff, 7, 50);
        run_random(80);

        // Writes to unused indexes must leave the shadow untouched
        write_reg(CFG_IDX_W'(5), $urandom);
        write_reg(CFG_IDX_W'(6), $urandom);
        write_reg(CFG_IDX_W'(7), 32'hffff_ffff);
        set_grid($urandom, $urandom, 37, 13, 64);
        run_random(100);

        // Tail: random grid, no idling on either side
        set_grid($urandom, $urandom, $urandom_range(1, 5000), $urandom_range(1, 64),
                 $urandom_range(1, 64));
        quiet_tail = 1'b1;
        run_random(150);

        repeat (40) @(posedge clk);
        if (exp_cells.size() != 0)
            report_mismatch($sformatf("%0d expected responses never arrived",
                                      exp_cells.size()));
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[grid_cell_min_max_binning_core.f]
rtl/gcmmb_pkg.sv
rtl/gcmmb_req_if.sv
rtl/gcmmb_rsp_if.sv
rtl/gcmmb_cfg_if.sv
rtl/gcmmb_div.sv
rtl/grid_cell_min_max_binning_core.sv
dv/tb_grid_cell_min_max_binning_core.sv
